// ----- hdl/html_tag_text_tokenizer_decoder_core_assert.svh -----
// Assertion macros shared by the tokenizer modules.
`ifndef HTML_TAG_TEXT_TOKENIZER_DECODER_CORE_ASSERT_SVH
`define HTML_TAG_TEXT_TOKENIZER_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

// ----- hdl/htmltok_pkg.sv -----
`timescale 1ns / 1ps

package htmltok_pkg;

   localparam int CharWidth  = 16;
   localparam int HoldDepth  = 5;
   localparam int EntCount   = 6;
   localparam int SpanLen    = 29;
   localparam int ShortLen   = 6;
   localparam int QueueDepth = 2;

   localparam int SpanCntW  = $clog2(SpanLen);
   localparam int HoldCntW  = $clog2(HoldDepth + 1);
   localparam int HoldIdxW  = $clog2(HoldDepth);
   localparam int EntIdxW   = $clog2(EntCount);
   localparam int ShortIdxW = $clog2(ShortLen);
   localparam int PosW      = SpanCntW + 1;
   localparam int QPtrW     = $clog2(QueueDepth);
   localparam int QCntW     = $clog2(QueueDepth + 1);

   localparam logic [SpanLen*8-1:0]  SpanPat  = "<span style='color:#000000;'>";
   localparam logic [ShortLen*8-1:0] ShortPat = "<span>";

   localparam logic [CharWidth-1:0] ChLt   = CharWidth'(60);
   localparam logic [CharWidth-1:0] ChGt   = CharWidth'(62);
   localparam logic [CharWidth-1:0] ChAmp  = CharWidth'(38);
   localparam logic [CharWidth-1:0] ChSemi = CharWidth'(59);

   typedef logic [CharWidth-1:0] char_type;

   // One request's worth of output: span prefix, held entity text and one
   // trailing character, or else the shortened span tag.
   typedef struct packed {
      logic [SpanCntW-1:0]       span_n;
      logic [HoldCntW-1:0]       held_n;
      char_type [HoldDepth-1:0]  held;
      logic                      x_valid;
      char_type                  x_char;
      logic                      x_tag;
      logic                      x_new;
      logic                      short_span;
      logic                      tag;
      logic                      begun;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic char_type span_char(input logic [SpanCntW-1:0] idx);
      logic [7:0] ch;
      ch = '0;
      if (int'(idx) < SpanLen) begin
         ch = SpanPat[(SpanLen - 1 - int'(idx))*8 +: 8];
      end
      return CharWidth'(ch);
   endfunction

   function automatic char_type short_char(input logic [ShortIdxW-1:0] idx);
      logic [7:0] ch;
      ch = '0;
      if (int'(idx) < ShortLen) begin
         ch = ShortPat[(ShortLen - 1 - int'(idx))*8 +: 8];
      end
      return CharWidth'(ch);
   endfunction

   // Entity order: nbsp lt gt quot apos amp.
   function automatic logic [HoldCntW-1:0] ent_len(input logic [EntIdxW-1:0] i);
      logic [HoldCntW-1:0] n;
      case (i)
         3'd0:    n = HoldCntW'(4);
         3'd1:    n = HoldCntW'(2);
         3'd2:    n = HoldCntW'(2);
         3'd3:    n = HoldCntW'(4);
         3'd4:    n = HoldCntW'(4);
         3'd5:    n = HoldCntW'(3);
         default: n = '0;
      endcase
      return n;
   endfunction

   function automatic char_type ent_val(input logic [EntIdxW-1:0] i);
      logic [7:0] ch;
      case (i)
         3'd0:    ch = 8'h20;
         3'd1:    ch = 8'h3C;
         3'd2:    ch = 8'h3E;
         3'd3:    ch = 8'h22;
         3'd4:    ch = 8'h27;
         3'd5:    ch = 8'h26;
         default: ch = 8'h00;
      endcase
      return CharWidth'(ch);
   endfunction

   function automatic char_type ent_name_char(input logic [EntIdxW-1:0] i,
                                              input logic [HoldCntW-1:0] pos);
      logic [31:0] nm;
      logic [7:0]  ch;
      case (i)
         3'd0:    nm = "nbsp";
         3'd1:    nm = {"lt", 16'h0000};
         3'd2:    nm = {"gt", 16'h0000};
         3'd3:    nm = "quot";
         3'd4:    nm = "apos";
         3'd5:    nm = {"amp", 8'h00};
         default: nm = '0;
      endcase
      ch = '0;
      if (int'(pos) < 4) begin
         ch = nm[(3 - int'(pos))*8 +: 8];
      end
      return CharWidth'(ch);
   endfunction

endpackage

// ----- hdl/html_tag_text_tokenizer_decoder_core.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_char_in, req_end_of_doc
// rsp      out        rsp_valid / rsp_ready  rsp_char_out, rsp_is_tag,
//                                            rsp_element_start, rsp_run_last
//
// The front end takes one request per cycle while the two-entry command queue
// has room, and a request that yields no character takes only that cycle.
// The back end emits one character per cycle while rsp_ready is high, and a
// request can yield up to 29 characters (for a flushed span prefix).
// Reset is synchronous and returns the tokenizer to text mode with nothing held.
// Output stalls back up through the queue into req_ready.

module html_tag_text_tokenizer_decoder_core import htmltok_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  char_type req_char_in,
   input  logic     req_end_of_doc,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output char_type rsp_char_out,
   output logic     rsp_is_tag,
   output logic     rsp_element_start,
   output logic     rsp_run_last
);

   qstat_type qstat;
   cmd_type   wr_cmd, rd_cmd;
   logic      accept, push, pop;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;

   htmltok_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_in    (req_char_in),
      .end_of_doc (req_end_of_doc),
      .push       (push),
      .cmd        (wr_cmd)
   );

   htmltok_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_cmd (wr_cmd),
      .pop    (pop),
      .rd_cmd (rd_cmd),
      .qstat  (qstat)
   );

   htmltok_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd               (rd_cmd),
      .qstat             (qstat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_char_out      (rsp_char_out),
      .rsp_is_tag        (rsp_is_tag),
      .rsp_element_start (rsp_element_start),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

// ----- hdl/htmltok_front.sv -----
`timescale 1ns / 1ps

module htmltok_front import htmltok_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  char_type char_in,
   input  logic     end_of_doc,
   output logic     push,
   output cmd_type  cmd
);

   logic                     in_tag_ff, in_tag_in;
   logic                     begun_ff, begun_in;
   logic [SpanCntW-1:0]      span_n_ff, span_n_in;
   logic [HoldCntW-1:0]      held_n_ff, held_n_in;
   char_type [HoldDepth-1:0] held_ff, held_in;
   logic [EntCount-1:0]      cand_ff, cand_in;

   logic                d_flush, d_xv, d_extend, d_start, semi_hit;
   char_type            d_x, semi_val;
   logic [EntCount-1:0] next_cand;
   logic [HoldCntW-1:0] pos;

   logic                use_dec, flush_held, boundary, nonempty;
   logic [SpanCntW-1:0] span_emit;

   // Entity decoder for one character against the held candidate.
   always_comb begin
      d_flush   = 1'b0;
      d_xv      = 1'b0;
      d_x       = char_in;
      d_extend  = 1'b0;
      d_start   = 1'b0;
      semi_hit  = 1'b0;
      semi_val  = '0;
      next_cand = '0;
      pos       = held_n_ff - HoldCntW'(1);
      for (int i = EntCount - 1; i >= 0; i--) begin
         if (cand_ff[i] && ent_len(EntIdxW'(i)) == pos) begin
            semi_hit = 1'b1;
            semi_val = ent_val(EntIdxW'(i));
         end
      end
      for (int i = 0; i < EntCount; i++) begin
         next_cand[i] = cand_ff[i] && (pos < ent_len(EntIdxW'(i))) &&
                        (ent_name_char(EntIdxW'(i), pos) == char_in);
      end
      if (held_n_ff == '0) begin
         if (char_in == ChAmp) begin
            d_start = 1'b1;
         end else begin
            d_xv = 1'b1;
         end
      end else if (char_in == ChSemi && semi_hit) begin
         d_xv = 1'b1;
         d_x  = semi_val;
      end else if (next_cand != '0 && held_n_ff < HoldCntW'(HoldDepth)) begin
         d_extend = 1'b1;
      end else begin
         d_flush = 1'b1;
         if (char_in == ChAmp) begin
            d_start = 1'b1;
         end else begin
            d_xv = 1'b1;
         end
      end
   end

   always_comb begin
      in_tag_in  = in_tag_ff;
      span_n_in  = span_n_ff;
      held_n_in  = held_n_ff;
      held_in    = held_ff;
      cand_in    = cand_ff;
      use_dec    = 1'b0;
      flush_held = 1'b0;
      boundary   = 1'b0;
      span_emit  = '0;

      cmd            = '0;
      cmd.held       = held_ff;
      cmd.tag        = in_tag_ff;
      cmd.begun      = begun_ff;
      cmd.x_tag      = in_tag_ff;
      cmd.x_char     = char_in;

      if (!in_tag_ff) begin
         if (char_in == ChLt) begin
            flush_held = 1'b1;
            boundary   = 1'b1;
            in_tag_in  = 1'b1;
            span_n_in  = SpanCntW'(1);
            held_n_in  = '0;
            cand_in    = '0;
            if (end_of_doc) begin
               // The lone '<' flushes as the first character of a new tag.
               cmd.x_valid = 1'b1;
               cmd.x_tag   = 1'b1;
               cmd.x_new   = 1'b1;
            end
         end else if (char_in == ChGt) begin
            flush_held = end_of_doc;
         end else begin
            use_dec = 1'b1;
         end
      end else if (char_in == ChGt) begin
         boundary  = 1'b1;
         in_tag_in = 1'b0;
         span_n_in = '0;
         held_n_in = '0;
         cand_in   = '0;
         if (span_n_ff == SpanCntW'(SpanLen - 1)) begin
            cmd.short_span = 1'b1;
         end else begin
            span_emit   = span_n_ff;
            flush_held  = 1'b1;
            cmd.x_valid = 1'b1;
         end
      end else if (char_in == ChLt) begin
         if (end_of_doc) begin
            span_emit  = span_n_ff;
            flush_held = 1'b1;
         end
      end else if (span_n_ff != '0 && char_in == span_char(span_n_ff)) begin
         span_n_in = span_n_ff + SpanCntW'(1);
         if (end_of_doc) begin
            span_emit = span_n_in;
         end
      end else begin
         span_emit = span_n_ff;
         span_n_in = '0;
         use_dec   = 1'b1;
      end

      if (use_dec) begin
         flush_held  = d_flush;
         cmd.x_valid = d_xv;
         cmd.x_char  = d_x;
         if (d_extend) begin
            held_n_in = held_n_ff + HoldCntW'(1);
            held_in[held_n_ff[HoldIdxW-1:0]] = char_in;
            cand_in = next_cand;
         end else if (d_start) begin
            held_n_in  = HoldCntW'(1);
            held_in[0] = ChAmp;
            cand_in    = '1;
         end else begin
            held_n_in = '0;
            cand_in   = '0;
         end
         // At the end of the document a partial entity goes out as is.
         if (end_of_doc && d_extend) begin
            flush_held  = 1'b1;
            cmd.x_valid = 1'b1;
            cmd.x_char  = char_in;
         end else if (end_of_doc && d_start) begin
            cmd.x_valid = 1'b1;
            cmd.x_char  = ChAmp;
         end
      end

      cmd.span_n = span_emit;
      cmd.held_n = flush_held ? held_n_ff : '0;
      nonempty   = cmd.short_span || cmd.x_valid || (span_emit != '0) ||
                   (cmd.held_n != '0);

      if (boundary || end_of_doc) begin
         begun_in = 1'b0;
      end else begin
         begun_in = begun_ff || nonempty;
      end

      if (end_of_doc) begin
         in_tag_in = 1'b0;
         span_n_in = '0;
         held_n_in = '0;
         cand_in   = '0;
      end
   end

   assign push = accept && nonempty;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff <= 1'b0;
         begun_ff  <= 1'b0;
         span_n_ff <= '0;
         held_n_ff <= '0;
         cand_ff   <= '0;
      end else if (accept) begin
         in_tag_ff <= in_tag_in;
         begun_ff  <= begun_in;
         span_n_ff <= span_n_in;
         held_n_ff <= held_n_in;
         cand_ff   <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

// ----- hdl/htmltok_queue.sv -----
`timescale 1ns / 1ps
`include "html_tag_text_tokenizer_decoder_core_assert.svh"

module htmltok_queue import htmltok_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   wr_cmd,
   input  logic      pop,
   output cmd_type   rd_cmd,
   output qstat_type qstat
);

   cmd_type          mem_ff [QueueDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0] count_ff;

   assign qstat.full  = (count_ff == QCntW'(QueueDepth));
   assign qstat.empty = (count_ff == '0);
   assign rd_cmd      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0
                                                               : wr_ptr_ff + QPtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0
                                                               : rd_ptr_ff + QPtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   `HTT_ASSERT_NOW(a_no_overflow, clock, reset, push, !qstat.full)
   `HTT_ASSERT_NOW(a_no_underflow, clock, reset, pop, !qstat.empty)

endmodule

// ----- hdl/htmltok_back.sv -----
`timescale 1ns / 1ps
`include "html_tag_text_tokenizer_decoder_core_assert.svh"

module htmltok_back import htmltok_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  qstat_type qstat,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output char_type  rsp_char_out,
   output logic      rsp_is_tag,
   output logic      rsp_element_start,
   output logic      rsp_run_last
);

   logic [PosW-1:0] pos_ff, len, hoff;
   logic            rsp_valid_ff, rsp_is_tag_ff, rsp_start_ff, rsp_last_ff;
   char_type        rsp_char_ff;

   logic            load, at_last, c_tag, c_start;
   char_type        c_char;

   always_comb begin
      if (cmd.short_span) begin
         len = PosW'(ShortLen);
      end else begin
         len = PosW'(cmd.span_n) + PosW'(cmd.held_n) + PosW'(cmd.x_valid);
      end
      at_last = (pos_ff == len - PosW'(1));
      hoff    = pos_ff - PosW'(cmd.span_n);

      c_tag   = cmd.tag;
      c_start = (pos_ff == '0) && !cmd.begun;
      if (cmd.short_span) begin
         c_char = short_char(pos_ff[ShortIdxW-1:0]);
      end else if (pos_ff < PosW'(cmd.span_n)) begin
         c_char = span_char(pos_ff[SpanCntW-1:0]);
      end else if (hoff < PosW'(cmd.held_n)) begin
         c_char = cmd.held[hoff[HoldIdxW-1:0]];
      end else begin
         // The trailing character may open a new element of the other kind.
         c_char  = cmd.x_char;
         c_tag   = cmd.x_tag;
         c_start = cmd.x_new || c_start;
      end
   end

   assign load = !qstat.empty && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            pos_ff       <= at_last ? '0 : pos_ff + PosW'(1);
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_char_ff   <= c_char;
         rsp_is_tag_ff <= c_tag;
         rsp_start_ff  <= c_start;
         rsp_last_ff   <= at_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_out      = rsp_char_ff;
   assign rsp_is_tag        = rsp_is_tag_ff;
   assign rsp_element_start = rsp_start_ff;
   assign rsp_run_last      = rsp_last_ff;

   `HTT_ASSERT_NEXT(a_pop_marks_last, clock, reset, pop, rsp_valid_ff && rsp_last_ff)
   `HTT_ASSERT_NOW(a_pos_in_range, clock, reset, !qstat.empty, pos_ff < len)
   `HTT_ASSERT_NOW(a_idle_pos_zero, clock, reset, qstat.empty, pos_ff == '0)

endmodule
